// ===== rtl/ffa_pkg.sv =====
// Shared types and constants for the first-fit aligned block allocator.
// Used by ffa_ctrl, ffa_dp and the top level; depends on nothing.
package ffa_pkg;

  // Default table depth and alignment grain (log2 of bytes)
  localparam int unsigned MAX_BLOCKS_DEF  = 16;
  localparam int unsigned ALIGN_SHIFT_DEF = 8;

  // Field widths fixed by the item format
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_SPACE  = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } ffa_status_t;

  // Request kinds
  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } ffa_mode_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD,
    S_CHK,
    S_ALIGN,
    S_TAIL,
    S_SHIFT,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_RM_TEST,
    S_RM_RD,
    S_RM_WR,
    S_RESP
  } ffa_state_t;

  // Table read address source
  typedef enum logic [1:0] {
    RSEL_IDX,
    RSEL_KM1,
    RSEL_KP1
  } ffa_rsel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic        load;        // capture the accepted item
    logic        idx_clr;
    logic        idx_inc;
    logic        k_load_cnt;  // shift pointer starts at the entry count
    logic        k_load_idx;  // shift pointer starts at the walk index
    logic        k_dec;
    logic        k_inc;
    ffa_rsel_t   rd_sel;
    logic        wr_en;
    logic        wr_put;      // write the new block at the walk index
    logic        start_zero;
    logic        end_calc;    // end = offset + size of the entry just read
    logic        align;       // start = end rounded up to the grain
    logic        cnt_inc;
    logic        cnt_dec;
    logic        res_set;
    ffa_status_t res_code;
    logic        res_grant;
    logic        emit;        // move the pending result to the output register
  } ffa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mode_free;
    logic cnt_zero;
    logic cnt_full;
    logic fit_empty;
    logic fit_next;
    logic fit_tail;
    logic idx_last;
    logic off_match;
    logic k_gt_idx;
    logic k_more;
    logic out_free;
  } ffa_stat_t;

endpackage

// ===== rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the block table; no dependencies.
module ffa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ffa_dp.sv =====
// Datapath of the allocator: request, walk and shift registers, fit tests,
// capacity register, result register and the block table RAM. Uses ffa_pkg, ffa_ram.
module ffa_dp #(
  parameter int unsigned MAX_BLOCKS  = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ALIGN_SHIFT = ffa_pkg::ALIGN_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ffa_pkg::ffa_cmd_t                  cmd,
  output ffa_pkg::ffa_stat_t                 stat,
  input  logic [ffa_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [0:0]                         in_tuser,
  input  logic                               cfg_valid,
  input  logic [ffa_pkg::DATA_W-1:0]         cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ffa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [ffa_pkg::STATUS_W-1:0]       out_tuser
);
  import ffa_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_BLOCKS);
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW  = DATA_W + 1;          // offset + size
  localparam int unsigned SW  = DATA_W + 2;          // aligned start
  localparam int unsigned FW  = SW + 1;              // start + size
  localparam int unsigned RW  = 2 * DATA_W;          // table entry
  localparam logic [SW-1:0] GRAIN_M1 = SW'((64'd1 << ALIGN_SHIFT) - 64'd1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_BLOCKS);

  // Request and walk registers
  ffa_mode_t           mode_r;
  logic [DATA_W-1:0]   size_r;
  logic [DATA_W-1:0]   off_r;
  logic [DATA_W-1:0]   cap_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       k_r;
  logic [EW-1:0]       end_r;
  logic [SW-1:0]       start_r;
  ffa_status_t         res_code_r;
  logic [DATA_W-1:0]   res_grant_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_grant_r;
  ffa_status_t         out_code_r;

  // Table port signals
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [RW-1:0]       wr_data;
  logic [RW-1:0]       rd_data;
  logic [DATA_W-1:0]   ent_off;
  logic [DATA_W-1:0]   ent_size;
  logic [CW-1:0]       k_m1;
  logic [CW-1:0]       k_p1;
  logic [SW-1:0]       rnd_sum;
  logic [FW-1:0]       start_plus;

  assign ent_off  = rd_data[DATA_W-1:0];
  assign ent_size = rd_data[RW-1:DATA_W];
  assign k_m1     = k_r - CW'(1);
  assign k_p1     = k_r + CW'(1);

  // Select read address
  always_comb begin
    case (cmd.rd_sel)
      RSEL_IDX: rd_addr = idx_r[AW-1:0];
      RSEL_KM1: rd_addr = k_m1[AW-1:0];
      RSEL_KP1: rd_addr = k_p1[AW-1:0];
      default:  rd_addr = idx_r[AW-1:0];
    endcase
  end

  // Write the new block at the walk index, or move a shifted entry to k
  assign wr_addr = cmd.wr_put ? idx_r[AW-1:0] : k_r[AW-1:0];
  assign wr_data = cmd.wr_put ? {size_r, start_r[DATA_W-1:0]} : rd_data;

  ffa_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Fit tests and walk status
  assign rnd_sum    = SW'(end_r) + GRAIN_M1;
  assign start_plus = FW'(start_r) + FW'(size_r);

  always_comb begin
    stat.mode_free = (mode_r == MODE_FREE);
    stat.cnt_zero  = (count_r == '0);
    stat.cnt_full  = (count_r >= MAX_CNT);
    stat.fit_empty = (size_r <= cap_r);
    stat.fit_next  = (idx_r != '0) && (start_plus <= FW'(ent_off));
    stat.fit_tail  = (start_plus <= FW'(cap_r));
    stat.idx_last  = ({1'b0, idx_r} + (CW+1)'(1)) == {1'b0, count_r};
    stat.off_match = (ent_off == off_r);
    stat.k_gt_idx  = (k_r > idx_r);
    stat.k_more    = ({1'b0, k_r} + (CW+1)'(1)) < {1'b0, count_r};
    stat.out_free  = !out_valid_r || out_tready;
  end

  // Control registers: capacity, entry count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: request, walk pointers, candidate start, results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= ffa_mode_t'(in_tuser[0]);
      size_r <= in_tdata[DATA_W-1:0];
      off_r  <= in_tdata[IN_TDATA_W-1:DATA_W];
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.k_load_cnt) begin
      k_r <= count_r;
    end else if (cmd.k_load_idx) begin
      k_r <= idx_r;
    end else if (cmd.k_dec) begin
      k_r <= k_m1;
    end else if (cmd.k_inc) begin
      k_r <= k_p1;
    end
    if (cmd.end_calc) begin
      end_r <= EW'(ent_off) + EW'(ent_size);
    end
    if (cmd.start_zero) begin
      start_r <= '0;
    end else if (cmd.align) begin
      start_r <= (rnd_sum >> ALIGN_SHIFT) << ALIGN_SHIFT;
    end
    if (cmd.res_set) begin
      res_code_r  <= cmd.res_code;
      res_grant_r <= cmd.res_grant ? start_r[DATA_W-1:0] : '0;
    end
    if (cmd.emit) begin
      out_code_r  <= res_code_r;
      out_grant_r <= res_grant_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_grant_r;
  assign out_tuser  = out_code_r;

endmodule

// ===== rtl/ffa_ctrl.sv =====
// Controller state machine of the allocator: sequences the table walk,
// the entry shifts and the result hand-off. Uses ffa_pkg.
module ffa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ffa_pkg::ffa_stat_t stat,
  output ffa_pkg::ffa_cmd_t  cmd
);
  import ffa_pkg::*;

  ffa_state_t state_r;
  ffa_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_sel   = RSEL_IDX;
    cmd.res_code = STAT_OK;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.mode_free) begin
          if (stat.cnt_zero) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = STAT_EMPTY;
            state_nxt    = S_RESP;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_RD;
          end
        end else if (stat.cnt_zero) begin
          if (stat.fit_empty) begin
            cmd.start_zero = 1'b1;
            cmd.idx_clr    = 1'b1;
            cmd.k_load_cnt = 1'b1;
            state_nxt      = S_SHIFT;
          end else begin
            cmd.res_set  = 1'b1;
            cmd.res_code = STAT_NO_SPACE;
            state_nxt    = S_RESP;
          end
        end else if (stat.cnt_full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_FULL;
          state_nxt    = S_RESP;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_RD;
        end
      end
      // Fetch the entry at the walk index
      S_RD: begin
        cmd.rd_sel = RSEL_IDX;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (stat.mode_free) begin
          if (stat.off_match) begin
            cmd.k_load_idx = 1'b1;
            state_nxt      = S_RM_TEST;
          end else if (stat.idx_last) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = STAT_NOT_FOUND;
            state_nxt    = S_RESP;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end else if (stat.fit_next) begin
          cmd.k_load_cnt = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.end_calc = 1'b1;
          state_nxt    = S_ALIGN;
        end
      end
      // Round the block end up to form the next candidate
      S_ALIGN: begin
        cmd.align   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = stat.idx_last ? S_TAIL : S_RD;
      end
      S_TAIL: begin
        if (stat.fit_tail) begin
          cmd.k_load_cnt = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_NO_SPACE;
          state_nxt    = S_RESP;
        end
      end
      // Open a slot at the walk index, moving entries up one by one
      S_SHIFT: begin
        state_nxt = stat.k_gt_idx ? S_SH_RD : S_PUT;
      end
      S_SH_RD: begin
        cmd.rd_sel = RSEL_KM1;
        state_nxt  = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_en = 1'b1;
        cmd.k_dec = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_PUT: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_put    = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.res_set   = 1'b1;
        cmd.res_code  = STAT_OK;
        cmd.res_grant = 1'b1;
        state_nxt     = S_RESP;
      end
      // Close the gap left by a freed entry, moving entries down
      S_RM_TEST: begin
        if (stat.k_more) begin
          state_nxt = S_RM_RD;
        end else begin
          cmd.cnt_dec  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_OK;
          state_nxt    = S_RESP;
        end
      end
      S_RM_RD: begin
        cmd.rd_sel = RSEL_KP1;
        state_nxt  = S_RM_WR;
      end
      S_RM_WR: begin
        cmd.wr_en = 1'b1;
        cmd.k_inc = 1'b1;
        state_nxt = S_RM_TEST;
      end
      // Hand the result over once the output register is free
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/first_fit_aligned_block_allocator.sv =====
// First-fit aligned block allocator. Keeps up to MAX_BLOCKS allocated blocks
// (offset, size), sorted by offset, in a pool whose size is written on the cfg
// channel. An allocate item walks the table and grants the first gap that
// starts at a block end rounded up to 2^ALIGN_SHIFT bytes, or offset 0 when the
// table is empty; a free item removes the first block with the given offset.
// Every item gives one result item. One item is processed at a time: an
// allocate reads, checks and aligns each table entry it walks, then moves
// entries up one by one to open the slot and places the block; a free reads
// and compares each entry, then moves the later entries down. Every table
// read goes through the registered read port of the table RAM. A finished
// result waits in the output register while the next item is accepted.
module first_fit_aligned_block_allocator #(
  parameter int unsigned MAX_BLOCKS  = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ALIGN_SHIFT = ffa_pkg::ALIGN_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ffa_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] request_size, [63:32] block_offset
  input  logic [0:0]                      in_tuser,   // [0] mode
  // Result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ffa_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] granted_offset
  output logic [ffa_pkg::STATUS_W-1:0]    out_tuser,  // [2:0] status
  // Capacity register write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffa_pkg::DATA_W-1:0]      cfg_data
);
  import ffa_pkg::*;

  ffa_cmd_t  cmd;
  ffa_stat_t stat;

  // Capacity writes are always taken
  assign cfg_ready = 1'b1;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffa_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .ALIGN_SHIFT (ALIGN_SHIFT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/first_fit_aligned_block_allocator_tb.sv =====
// Self-checking testbench for the first-fit aligned block allocator.
// Drives allocate/free items and capacity writes, predicts every result item
// from its own copy of the block table; depends on ffa_pkg and the RTL only.
module first_fit_aligned_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffa_pkg::*;

  localparam int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF;
  localparam int unsigned ALIGN_SHIFT = ALIGN_SHIFT_DEF;
  localparam longint unsigned GRAIN   = 64'd1 << ALIGN_SHIFT;
  localparam int CLK_PERIOD   = 10;
  localparam int SETTLE_CYCLES = 5 * MAX_BLOCKS + 20;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 40;
  localparam int RUN_PHASES   = 8;

  typedef struct {
    ffa_status_t status;
    logic [31:0] offset;
  } grant_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] request_size, [63:32] block_offset
  logic [0:0]             in_tuser = '0;   // [0] mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] granted_offset
  logic [STATUS_W-1:0]    out_tuser;       // [2:0] status
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DATA_W-1:0]      cfg_data = '0;

  // Predicted copy of the block table and capacity
  logic [31:0] held_off  [MAX_BLOCKS];
  logic [31:0] held_size [MAX_BLOCKS];
  int          held_count = 0;
  logic [31:0] pool_capacity = '0;

  grant_t grants_due [$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     run_left [2] = '{0, 0};   // no-wait stretch per side: 0 sender, 1 receiver

  first_fit_aligned_block_allocator #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .ALIGN_SHIFT (ALIGN_SHIFT)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Draw the wait before one item; now and then hold a stretch with no waits
  function automatic int draw_wait(int side);
    if (run_left[side] > 0) begin
      run_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left[side] = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Open a slot at pos and store the new block there
  function automatic void pool_insert(int pos, logic [31:0] off, logic [31:0] size);
    for (int k = held_count; k > pos; k--) begin
      held_off[k]  = held_off[k - 1];
      held_size[k] = held_size[k - 1];
    end
    held_off[pos]  = off;
    held_size[pos] = size;
    held_count++;
  endfunction

  // Apply one request to the predicted table and return its result
  function automatic grant_t pool_apply_request(ffa_mode_t mode, logic [31:0] size,
                                                logic [31:0] off);
    grant_t g;
    logic [63:0] start;
    logic [63:0] limit;
    g.status = STAT_OK;
    g.offset = '0;
    if (mode == MODE_ALLOC) begin
      if (held_count == 0) begin
        if (size <= pool_capacity) pool_insert(0, '0, size);
        else g.status = STAT_NO_SPACE;
      end else if (held_count >= MAX_BLOCKS) begin
        g.status = STAT_FULL;
      end else begin
        // Walk the gaps after each block; sums are kept wide so nothing wraps
        g.status = STAT_NO_SPACE;
        for (int i = 0; i < held_count && g.status == STAT_NO_SPACE; i++) begin
          start = ((64'(held_off[i]) + 64'(held_size[i]) + GRAIN - 1) >> ALIGN_SHIFT)
                  << ALIGN_SHIFT;
          limit = (i + 1 < held_count) ? 64'(held_off[i + 1]) : 64'(pool_capacity);
          if (start + 64'(size) <= limit) begin
            g.status = STAT_OK;
            g.offset = start[31:0];
            pool_insert(i + 1, start[31:0], size);
          end
        end
      end
    end else if (held_count == 0) begin
      g.status = STAT_EMPTY;
    end else begin
      // Drop the first block with a matching offset
      g.status = STAT_NOT_FOUND;
      for (int i = 0; i < held_count && g.status == STAT_NOT_FOUND; i++) begin
        if (held_off[i] == off) begin
          for (int k = i; k + 1 < held_count; k++) begin
            held_off[k]  = held_off[k + 1];
            held_size[k] = held_size[k + 1];
          end
          held_count--;
          g.status = STAT_OK;
        end
      end
    end
    return g;
  endfunction

  // Send one request item and queue its predicted result at acceptance
  task automatic send_request(input ffa_mode_t mode, input logic [31:0] size,
                              input logic [31:0] off);
    int gap;
    gap = draw_wait(0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {off, size};
    do @(posedge clk); while (!in_tready);
    grants_due.push_back(pool_apply_request(mode, size, off));
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic wait_grants_done();
    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register while the block is idle
  task automatic set_capacity(input logic [31:0] value);
    wait_grants_done();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_capacity = value;
  endtask

  // Free every held block in random order
  task automatic free_all_blocks();
    while (held_count > 0)
      send_request(MODE_FREE, $urandom, held_off[$urandom_range(0, held_count - 1)]);
  endtask

  function automatic logic [31:0] draw_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      2:       return pool_capacity >> $urandom_range(0, 6);
      3, 4:    return $urandom_range(1, 256);
      default: return $urandom_range(1, 32'(3 * GRAIN));
    endcase
  endfunction

  // Zero capacity: only zero-size blocks fit, free on empty and unknown offsets
  task automatic test_empty_pool();
    send_request(MODE_ALLOC, 32'd1, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(MODE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_FREE, 32'hFFFF_FFFF, 32'd0);
    send_request(MODE_FREE, 32'hFFFF_FFFF, 32'd0);
    send_request(MODE_FREE, 32'hFFFF_FFFF, 32'd0);
  endtask

  // Full 32-bit pool: wide sums, zero-size duplicates, unused leading gap
  task automatic test_full_range_pool();
    set_capacity(32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(MODE_ALLOC, 32'd0, 32'd0);
    send_request(MODE_FREE, 32'd0, 32'd0);
    send_request(MODE_ALLOC, 32'd10, 32'd0);
    send_request(MODE_ALLOC, 32'd0, 32'd0);
    send_request(MODE_ALLOC, 32'd0, 32'd0);
    send_request(MODE_FREE, 32'd0, 32'd256);
    send_request(MODE_FREE, 32'd0, 32'd0);
    send_request(MODE_ALLOC, 32'd10, 32'd0);
    send_request(MODE_ALLOC, 32'hFFFF_FDFF, 32'd0);
    send_request(MODE_ALLOC, 32'd1, 32'd0);
    send_request(MODE_FREE, 32'd0, 32'd512);
    free_all_blocks();
  endtask

  // Fill the table, hit the full case, refill one slot and hit it again
  task automatic test_table_full();
    set_capacity(32'h0010_0000);
    repeat (MAX_BLOCKS) send_request(MODE_ALLOC, $urandom_range(1, 1000), $urandom);
    send_request(MODE_ALLOC, 32'd0, $urandom);
    send_request(MODE_FREE, $urandom, held_off[$urandom_range(0, held_count - 1)]);
    send_request(MODE_ALLOC, $urandom_range(0, 300), $urandom);
    send_request(MODE_ALLOC, $urandom_range(0, 300), $urandom);
    free_all_blocks();
  endtask

  // Mixed traffic over several capacities, mostly allocates, the rest frees
  task automatic test_random_traffic();
    logic [31:0] cap;
    int          pick;
    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      case (ph % 6)
        0:       cap = 32'hFFFF_FFFF;
        1:       cap = '0;
        2:       cap = 32'(MAX_BLOCKS * GRAIN);
        3:       cap = $urandom_range(0, 32'h2000);
        4:       cap = $urandom;
        default: cap = $urandom_range(0, 32'h0001_0000);
      endcase
      set_capacity(cap);
      if ($urandom_range(0, 1) == 0) free_all_blocks();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender until the pipeline is empty
        if (n == PHASE_ITEMS / 2) wait_grants_done();
        pick = $urandom_range(0, 9);
        if (held_count > 0 && pick < 4) begin
          send_request(MODE_FREE, $urandom, held_off[$urandom_range(0, held_count - 1)]);
        end else if (pick == 4) begin
          send_request(MODE_FREE, $urandom,
                       held_count > 0 ? held_off[$urandom_range(0, held_count - 1)] + 32'd1
                                      : $urandom);
        end else begin
          send_request(MODE_ALLOC, draw_size(), $urandom);
        end
      end
    end
  endtask

  // Accept and check each result item against the oldest prediction
  initial begin : result_monitor
    int          stall;
    grant_t      want;
    ffa_status_t got_status;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(1);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got_status = ffa_status_t'(out_tuser);
      if (grants_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result item: status %0d offset %h", out_tuser, out_tdata);
      end else begin
        want = grants_due.pop_front();
        if (got_status !== want.status || out_tdata !== want.offset) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: status exp %0d got %0d, offset exp %h got %h",
                     want.status, out_tuser, want.offset, out_tdata);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      held_off[i]  = '0;
      held_size[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pool();
    test_full_range_pool();
    test_table_full();
    test_random_traffic();
    set_capacity('0);
    send_request(MODE_ALLOC, 32'd0, $urandom);
    send_request(MODE_ALLOC, 32'd5, $urandom);
    wait_grants_done();
    if (mismatch_count == 0 && grants_due.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
